// ----- rtl/arp_responder_defines.svh -----
// assertion macros for the arp responder rtl
// used by arp_responder.sv; expects a clock named clk and reset named rst_n
`ifndef ARP_RESPONDER_DEFINES_SVH
`define ARP_RESPONDER_DEFINES_SVH

// clocked check, masked while reset is held
`define ARP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define ARP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/arp_pkg.sv -----
// shared types, constants and byte-order helpers for the arp responder
// no dependencies
package arp_pkg;

  // frame word counter
  localparam int WORD_INDEX_BITS = 8;
  typedef logic [WORD_INDEX_BITS-1:0] widx_t;
  localparam widx_t WIDX_W0 = widx_t'(0);
  localparam widx_t WIDX_W1 = widx_t'(1);
  localparam widx_t WIDX_W2 = widx_t'(2);
  localparam widx_t WIDX_W3 = widx_t'(3);
  localparam widx_t WIDX_W4 = widx_t'(4);
  localparam widx_t WIDX_W5 = widx_t'(5);

  // configuration port
  localparam int CFG_DATA_W = 48;
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_OWN_MAC = 1'b0;
  localparam cfg_idx_t CFG_OWN_IP  = 1'b1;

  // stream widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 160;

  // input selector and result kind
  localparam logic MODE_RX     = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_BIND   = 1'b1;

  // protocol constants
  localparam logic [7:0]  KEEP_FULL    = 8'hFF;
  localparam logic [7:0]  KEEP_LAST    = 8'h03;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETYPE_ARP    = 16'h0806;
  localparam logic [15:0] HTYPE_ETH    = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  HLEN_ETH     = 8'd6;
  localparam logic [7:0]  PLEN_IPV4    = 8'd4;
  localparam logic [15:0] OPER_REQUEST = 16'd1;
  localparam logic [15:0] OPER_REPLY   = 16'd2;

  // output sequencer steps: binding update, then frame words 0..5
  typedef logic [2:0] step_t;
  localparam step_t STEP_BIND = 3'd0;
  localparam step_t STEP_W0   = 3'd1;
  localparam step_t STEP_W1   = 3'd2;
  localparam step_t STEP_W2   = 3'd3;
  localparam step_t STEP_W3   = 3'd4;
  localparam step_t STEP_W4   = 3'd5;
  localparam step_t STEP_W5   = 3'd6;

  // one pending emission job
  typedef struct packed {
    logic        has_bind;
    logic        has_frame;
    logic [47:0] dst;
    logic [15:0] etype;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] oper;
    logic [47:0] tha;
    logic [31:0] tpa;
  } job_t;

  // network byte order <-> lane order (first lane holds the top byte)
  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [47:0] swap48(input logic [47:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24], v[39:32], v[47:40]};
  endfunction

endpackage

// ----- rtl/arp_responder.sv -----
// arp responder: an accepted item is held in the job register and its results are
// built from it into the output register; results leave one per cycle while
// out_tready is high. non-final receive words are taken every cycle; an item
// that causes results holds the emission sequencer for a binding update, six
// frame words (request) or both; the next such item is taken as the last one is loaded.
// reset (synchronous, active low) clears the word counter, sequencer, output
// valid and both address registers; parsed header fields are not reset.
// depends on arp_pkg and arp_responder_defines.svh
`include "arp_responder_defines.svh"

module arp_responder (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  arp_pkg::cfg_idx_t              cfg_addr,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [arp_pkg::IN_DATA_W-1:0]  in_tdata,   // rx_data[63:0], query_ip[95:64]
  input  logic                           in_tuser,   // mode
  input  logic                           in_tlast,   // rx_end
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [arp_pkg::OUT_DATA_W-1:0] out_tdata,  // tx_data[63:0], tx_keep[71:64],
                                                     // bind_mac[119:72], bind_ip[151:120],
                                                     // run_last[152], zero[159:153]
  output logic                           out_tuser,  // kind
  output logic                           out_tlast   // tx_end
);
  import arp_pkg::*;

  // configuration registers
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_OWN_MAC: own_mac_r <= cfg_wdata;
        CFG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
        default:     own_mac_r <= own_mac_r;
      endcase
    end
  end

  // input fields
  logic [63:0] rx_data;
  logic [31:0] query_ip;
  assign rx_data  = in_tdata[63:0];
  assign query_ip = in_tdata[95:64];

  // parse state
  widx_t       word_index_r, word_index_nxt;
  logic [47:0] peer_mac_r, peer_mac_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [15:0] hw_type_r, hw_type_nxt;
  logic [15:0] proto_type_r, proto_type_nxt;
  logic [7:0]  hw_len_r, hw_len_nxt;
  logic [7:0]  proto_len_r, proto_len_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [47:0] sender_mac_r, sender_mac_nxt;
  logic [31:0] sender_ip_r, sender_ip_nxt;
  logic [31:0] target_ip_r, target_ip_nxt;

  // emission job and sequencer
  job_t  job_r, job_nxt;
  logic  job_valid_r, job_valid_nxt;
  step_t step_r, step_nxt;
  step_t last_step;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [63:0] out_data_r;
  logic [7:0]  out_keep_r;
  logic        out_end_r;
  logic [47:0] out_mac_r;
  logic [31:0] out_ip_r;
  logic        out_run_last_r;

  // handshake control
  logic in_fire, in_rx, in_makes_results, load_out, job_done, job_free, reply_hit;

  assign in_rx            = (in_tuser == MODE_RX);
  assign in_makes_results = !in_rx || in_tlast;
  assign last_step        = job_r.has_frame ? STEP_W5 : STEP_BIND;
  assign load_out         = job_valid_r && (!out_valid_r || out_tready);
  assign job_done         = load_out && (step_r == last_step);
  assign job_free         = !job_valid_r || job_done;
  assign in_tready        = job_free || (in_rx && !in_tlast);
  assign in_fire          = in_tvalid && in_tready;

  // header parse of the current receive word
  always_comb begin
    peer_mac_nxt   = peer_mac_r;
    etype_nxt      = etype_r;
    hw_type_nxt    = hw_type_r;
    proto_type_nxt = proto_type_r;
    hw_len_nxt     = hw_len_r;
    proto_len_nxt  = proto_len_r;
    opcode_nxt     = opcode_r;
    sender_mac_nxt = sender_mac_r;
    sender_ip_nxt  = sender_ip_r;
    target_ip_nxt  = target_ip_r;
    case (word_index_r)
      WIDX_W0: begin
        peer_mac_nxt[47:32] = swap16(rx_data[63:48]);
      end
      WIDX_W1: begin
        peer_mac_nxt[31:0] = swap32(rx_data[31:0]);
        etype_nxt          = swap16(rx_data[47:32]);
        hw_type_nxt        = swap16(rx_data[63:48]);
      end
      WIDX_W2: begin
        proto_type_nxt        = swap16(rx_data[15:0]);
        hw_len_nxt            = rx_data[23:16];
        proto_len_nxt         = rx_data[31:24];
        opcode_nxt            = swap16(rx_data[47:32]);
        sender_mac_nxt[47:32] = swap16(rx_data[63:48]);
      end
      WIDX_W3: begin
        sender_mac_nxt[31:0] = swap32(rx_data[31:0]);
        sender_ip_nxt        = swap32(rx_data[63:32]);
      end
      WIDX_W4: begin
        target_ip_nxt[31:16] = swap16(rx_data[63:48]);
      end
      WIDX_W5: begin
        target_ip_nxt[15:0] = swap16(rx_data[15:0]);
      end
      default: begin
        target_ip_nxt = target_ip_r;
      end
    endcase
  end

  // word counter: restarts after the last word, wraps on long frames
  always_comb begin
    word_index_nxt = word_index_r;
    if (in_fire && in_rx) begin
      word_index_nxt = in_tlast ? WIDX_W0 : word_index_r + widx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= WIDX_W0;
    end else begin
      word_index_r <= word_index_nxt;
    end
  end

  // header fields, no reset
  always_ff @(posedge clk) begin
    if (in_fire && in_rx) begin
      peer_mac_r   <= peer_mac_nxt;
      etype_r      <= etype_nxt;
      hw_type_r    <= hw_type_nxt;
      proto_type_r <= proto_type_nxt;
      hw_len_r     <= hw_len_nxt;
      proto_len_r  <= proto_len_nxt;
      opcode_r     <= opcode_nxt;
      sender_mac_r <= sender_mac_nxt;
      sender_ip_r  <= sender_ip_nxt;
      target_ip_r  <= target_ip_nxt;
    end
  end

  // reply when a request names our address
  assign reply_hit = (opcode_nxt == OPER_REQUEST) && (target_ip_nxt == own_ip_r);

  // job capture
  always_comb begin
    job_nxt = job_r;
    if (in_rx) begin
      job_nxt.has_bind  = 1'b1;
      job_nxt.has_frame = reply_hit;
      job_nxt.dst       = peer_mac_nxt;
      job_nxt.etype     = etype_nxt;
      job_nxt.htype     = hw_type_nxt;
      job_nxt.ptype     = proto_type_nxt;
      job_nxt.hlen      = hw_len_nxt;
      job_nxt.plen      = proto_len_nxt;
      job_nxt.oper      = OPER_REPLY;
      job_nxt.tha       = sender_mac_nxt;
      job_nxt.tpa       = sender_ip_nxt;
    end else begin
      job_nxt.has_bind  = 1'b0;
      job_nxt.has_frame = 1'b1;
      job_nxt.dst       = MAC_BCAST;
      job_nxt.etype     = ETYPE_ARP;
      job_nxt.htype     = HTYPE_ETH;
      job_nxt.ptype     = PTYPE_IPV4;
      job_nxt.hlen      = HLEN_ETH;
      job_nxt.plen      = PLEN_IPV4;
      job_nxt.oper      = OPER_REQUEST;
      job_nxt.tha       = '0;
      job_nxt.tpa       = query_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_makes_results) begin
      job_r <= job_nxt;
    end
  end

  // sequencer control
  always_comb begin
    job_valid_nxt = job_valid_r;
    step_nxt      = step_r;
    if (in_fire && in_makes_results) begin
      job_valid_nxt = 1'b1;
      step_nxt      = in_rx ? STEP_BIND : STEP_W0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (load_out) begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= STEP_BIND;
    end else begin
      job_valid_r <= job_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // result build for the current step
  logic [63:0] res_data;
  logic        res_kind;
  logic [7:0]  res_keep;
  logic        res_end;
  logic [47:0] res_mac;
  logic [31:0] res_ip;

  always_comb begin
    res_kind = KIND_FRAME;
    res_keep = KEEP_FULL;
    res_end  = 1'b0;
    res_mac  = '0;
    res_ip   = '0;
    res_data = '0;
    case (step_r)
      STEP_W0: res_data = {swap16(own_mac_r[47:32]), swap48(job_r.dst)};
      STEP_W1: res_data = {swap16(job_r.htype), swap16(job_r.etype),
                           swap32(own_mac_r[31:0])};
      STEP_W2: res_data = {swap16(own_mac_r[47:32]), swap16(job_r.oper),
                           job_r.plen, job_r.hlen, swap16(job_r.ptype)};
      STEP_W3: res_data = {swap32(own_ip_r), swap32(own_mac_r[31:0])};
      STEP_W4: res_data = {swap16(job_r.tpa[31:16]), swap48(job_r.tha)};
      STEP_W5: begin
        res_data = {48'h0, swap16(job_r.tpa[15:0])};
        res_keep = KEEP_LAST;
        res_end  = 1'b1;
      end
      default: begin
        res_kind = KIND_BIND;
        res_keep = '0;
        res_mac  = job_r.tha;
        res_ip   = job_r.tpa;
      end
    endcase
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r     <= res_kind;
      out_data_r     <= res_data;
      out_keep_r     <= res_keep;
      out_end_r      <= res_end;
      out_mac_r      <= res_mac;
      out_ip_r       <= res_ip;
      out_run_last_r <= (step_r == last_step);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_end_r;
  assign out_tdata  = {7'h0, out_run_last_r, out_ip_r, out_mac_r, out_keep_r, out_data_r};

  // checks
  `ARP_ASSERT(a_step_range, job_valid_r |-> (step_r <= STEP_W5),
              "sequencer step out of range")
  `ARP_ASSERT(a_no_overrun, (in_fire && in_makes_results) |-> job_free,
              "result item taken while a job is still emitting")
  `ARP_ASSERT(a_frame_end, (out_valid_r && out_end_r) |->
              (out_run_last_r && (out_keep_r == KEEP_LAST) && (out_kind_r == KIND_FRAME)),
              "final frame word without run end or short keep")
  `ARP_ASSERT(a_bind_first, (load_out && (step_r == STEP_BIND)) |-> job_r.has_bind,
              "binding update emitted for a request job")
  `ARP_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid_r && !job_valid_r),
                  "output or job valid after reset")

endmodule

// ----- dv/tb_top.sv -----
// testbench for arp_responder: directed frame table, then randomized arp traffic
// self-checking against an in-bench arp parse/reply predictor; depends on arp_pkg
`timescale 1ns / 1ps

module tb_top;
  import arp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG = 1000;
  localparam int MAX_REPORTS = 60;

  // one input item and one result item, as the block sees them
  typedef struct packed {
    logic        mode;
    logic [63:0] rx_data;
    logic        rx_end;
    logic [31:0] query_ip;
  } rx_item_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] tx_data;
    logic [7:0]  tx_keep;
    logic        tx_end;
    logic [47:0] bind_mac;
    logic [31:0] bind_ip;
    logic        run_last;
  } arp_result_t;

  // ethernet source plus arp header fields
  typedef struct packed {
    logic [47:0] peer_mac;
    logic [15:0] etype;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] oper;
    logic [47:0] sndr_mac;
    logic [31:0] sndr_ip;
    logic [31:0] tgt_ip;
  } arp_hdr_t;

  typedef logic [5:0][63:0] hdr_words_t;

  // directed row: stimulus plus a hand-read binding where one is typed in
  typedef struct packed {
    logic        mode;
    logic [63:0] rx_data;
    logic        rx_end;
    logic [31:0] query_ip;
    logic        has_bind;
    logic [47:0] bind_mac;
    logic [31:0] bind_ip;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_idx_t cfg_addr = CFG_OWN_MAC;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  // predictor copy of registers and parse state
  logic [47:0] my_mac = '0;
  logic [31:0] my_ip = '0;
  widx_t seen_idx = '0;
  arp_hdr_t seen = '0;

  arp_result_t outgoing_q [$];
  arp_result_t item_out [$];
  int mismatches = 0;
  int items_done = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  // frame A: request for 0.0.0.0, frame B: all ones, frame C: zero request
  frame_row_t frame_rows [24] = '{
    '{MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_QUERY, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h1102_FFFF_FFFF_FFFF, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0100_0608_5544_3322, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h1102_0100_0406_0008, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0100_000A_5544_3322, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b1, 32'h0, 1'b1, 48'h0211_2233_4455, 32'h0A00_0001},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_QUERY, 64'h0, 1'b0, 32'hC0A8_0001, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
      48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF},
    '{MODE_RX, 64'h0, 1'b1, 32'h0, 1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF},
    '{MODE_RX, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0000_0100_0000_0000, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b0, 32'h0, 1'b0, 48'h0, 32'h0},
    '{MODE_RX, 64'h0, 1'b1, 32'h0, 1'b1, 48'h0, 32'h0}
  };

  arp_responder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // rx_data[63:0], query_ip[95:64]
    .in_tuser   (in_tuser),   // mode
    .in_tlast   (in_tlast),   // rx_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // tx_data, tx_keep, bind_mac, bind_ip, run_last, zero pad
    .out_tuser  (out_tuser),  // kind
    .out_tlast  (out_tlast)   // tx_end
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // n bytes from a lane, first lane is the most significant byte
  function automatic logic [63:0] get_lanes(logic [63:0] w, int lane, int n);
    logic [63:0] v;
    int i;
    v = '0;
    for (i = 0; i < n; i++)
      v = (v << 8) | ((w >> (8 * (lane + i))) & 64'hFF);
    return v;
  endfunction

  // place the low n bytes of v from a lane on, most significant byte first
  function automatic logic [63:0] put_lanes(logic [63:0] w, int lane, int n, logic [63:0] v);
    int i;
    for (i = 0; i < n; i++)
      w |= ((v >> (8 * (n - 1 - i))) & 64'hFF) << (8 * (lane + i));
    return w;
  endfunction

  // six outgoing words of an arp frame sent from this node
  function automatic void queue_frame(logic [47:0] dst, logic [15:0] etype, logic [15:0] htype,
                                      logic [15:0] ptype, logic [7:0] hlen, logic [7:0] plen,
                                      logic [15:0] oper, logic [47:0] tha, logic [31:0] tpa);
    hdr_words_t w;
    arp_result_t r;
    int i;
    w = '0;
    w[0] = put_lanes(w[0], 0, 6, 64'(dst));
    w[0] = put_lanes(w[0], 6, 2, 64'(my_mac[47:32]));
    w[1] = put_lanes(w[1], 0, 4, 64'(my_mac[31:0]));
    w[1] = put_lanes(w[1], 4, 2, 64'(etype));
    w[1] = put_lanes(w[1], 6, 2, 64'(htype));
    w[2] = put_lanes(w[2], 0, 2, 64'(ptype));
    w[2] = put_lanes(w[2], 2, 1, 64'(hlen));
    w[2] = put_lanes(w[2], 3, 1, 64'(plen));
    w[2] = put_lanes(w[2], 4, 2, 64'(oper));
    w[2] = put_lanes(w[2], 6, 2, 64'(my_mac[47:32]));
    w[3] = put_lanes(w[3], 0, 4, 64'(my_mac[31:0]));
    w[3] = put_lanes(w[3], 4, 4, 64'(my_ip));
    w[4] = put_lanes(w[4], 0, 6, 64'(tha));
    w[4] = put_lanes(w[4], 6, 2, 64'(tpa[31:16]));
    w[5] = put_lanes(w[5], 0, 2, 64'(tpa[15:0]));
    for (i = 0; i < 6; i++) begin
      r = '0;
      r.kind = KIND_FRAME;
      r.tx_data = w[i];
      r.tx_keep = (i == 5) ? KEEP_LAST : KEEP_FULL;
      r.tx_end = (i == 5);
      item_out.push_back(r);
    end
  endfunction

  // header fields carried by one received word
  function automatic void absorb_word(widx_t idx, logic [63:0] w);
    case (idx)
      WIDX_W0: seen.peer_mac[47:32] = 16'(get_lanes(w, 6, 2));
      WIDX_W1: begin
        seen.peer_mac[31:0] = 32'(get_lanes(w, 0, 4));
        seen.etype = 16'(get_lanes(w, 4, 2));
        seen.htype = 16'(get_lanes(w, 6, 2));
      end
      WIDX_W2: begin
        seen.ptype = 16'(get_lanes(w, 0, 2));
        seen.hlen = 8'(get_lanes(w, 2, 1));
        seen.plen = 8'(get_lanes(w, 3, 1));
        seen.oper = 16'(get_lanes(w, 4, 2));
        seen.sndr_mac[47:32] = 16'(get_lanes(w, 6, 2));
      end
      WIDX_W3: begin
        seen.sndr_mac[31:0] = 32'(get_lanes(w, 0, 4));
        seen.sndr_ip = 32'(get_lanes(w, 4, 4));
      end
      WIDX_W4: seen.tgt_ip[31:16] = 16'(get_lanes(w, 6, 2));
      WIDX_W5: seen.tgt_ip[15:0] = 16'(get_lanes(w, 0, 2));
      default: ;
    endcase
  endfunction

  // results caused by one accepted item; a typed binding replaces the predicted one
  function automatic void predict_item(rx_item_t it, logic pin, logic [47:0] pmac,
                                       logic [31:0] pip);
    arp_result_t r;
    int k;
    item_out.delete();
    if (it.mode == MODE_QUERY) begin
      queue_frame(MAC_BCAST, ETYPE_ARP, HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4,
                  OPER_REQUEST, 48'h0, it.query_ip);
    end else begin
      absorb_word(seen_idx, it.rx_data);
      if (it.rx_end) begin
        r = '0;
        r.kind = KIND_BIND;
        r.bind_mac = pin ? pmac : seen.sndr_mac;
        r.bind_ip = pin ? pip : seen.sndr_ip;
        item_out.push_back(r);
        // answer requests aimed at this node
        if (seen.oper == OPER_REQUEST && seen.tgt_ip == my_ip)
          queue_frame(seen.peer_mac, seen.etype, seen.htype, seen.ptype, seen.hlen,
                      seen.plen, OPER_REPLY, seen.sndr_mac, seen.sndr_ip);
        seen_idx = '0;
      end else begin
        seen_idx = seen_idx + 1'b1;
      end
    end
    if (item_out.size() > 0) begin
      r = item_out.pop_back();
      r.run_last = 1'b1;
      item_out.push_back(r);
    end
    for (k = 0; k < item_out.size(); k++)
      outgoing_q.push_back(item_out[k]);
  endfunction

  // random header, often a request for this node
  function automatic arp_hdr_t make_hdr();
    arp_hdr_t h;
    int r;
    h.peer_mac = 48'({$urandom, $urandom});
    h.etype = ($urandom_range(7) == 0) ? 16'($urandom) : ETYPE_ARP;
    h.htype = ($urandom_range(7) == 0) ? 16'($urandom) : HTYPE_ETH;
    h.ptype = ($urandom_range(7) == 0) ? 16'($urandom) : PTYPE_IPV4;
    h.hlen = ($urandom_range(7) == 0) ? 8'($urandom) : HLEN_ETH;
    h.plen = ($urandom_range(7) == 0) ? 8'($urandom) : PLEN_IPV4;
    r = $urandom_range(99);
    if (r < 45)
      h.oper = OPER_REQUEST;
    else if (r < 80)
      h.oper = OPER_REPLY;
    else
      h.oper = 16'($urandom);
    h.sndr_mac = $urandom_range(1) ? h.peer_mac : 48'({$urandom, $urandom});
    h.sndr_ip = $urandom;
    h.tgt_ip = ($urandom_range(99) < 55) ? my_ip : 32'($urandom);
    return h;
  endfunction

  // words 0..5 of a received frame, random content in lanes the parser skips
  function automatic hdr_words_t pack_hdr(arp_hdr_t h);
    hdr_words_t w;
    w = '0;
    w[0] = put_lanes(w[0], 0, 6, {$urandom, $urandom});
    w[0] = put_lanes(w[0], 6, 2, 64'(h.peer_mac[47:32]));
    w[1] = put_lanes(w[1], 0, 4, 64'(h.peer_mac[31:0]));
    w[1] = put_lanes(w[1], 4, 2, 64'(h.etype));
    w[1] = put_lanes(w[1], 6, 2, 64'(h.htype));
    w[2] = put_lanes(w[2], 0, 2, 64'(h.ptype));
    w[2] = put_lanes(w[2], 2, 1, 64'(h.hlen));
    w[2] = put_lanes(w[2], 3, 1, 64'(h.plen));
    w[2] = put_lanes(w[2], 4, 2, 64'(h.oper));
    w[2] = put_lanes(w[2], 6, 2, 64'(h.sndr_mac[47:32]));
    w[3] = put_lanes(w[3], 0, 4, 64'(h.sndr_mac[31:0]));
    w[3] = put_lanes(w[3], 4, 4, 64'(h.sndr_ip));
    w[4] = put_lanes(w[4], 0, 6, {$urandom, $urandom});
    w[4] = put_lanes(w[4], 6, 2, 64'(h.tgt_ip[31:16]));
    w[5] = put_lanes(w[5], 0, 2, 64'(h.tgt_ip[15:0]));
    w[5] = put_lanes(w[5], 2, 6, {$urandom, $urandom});
    return w;
  endfunction

  // offer one item, predict on acceptance, then maybe go idle
  task automatic push_item(input rx_item_t it, input logic pin, input logic [47:0] pmac,
                           input logic [31:0] pip);
    in_tvalid <= 1'b1;
    in_tuser <= it.mode;
    in_tlast <= it.rx_end;
    in_tdata <= {it.query_ip, it.rx_data};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_item(it, pin, pmac, pip);
    items_done++;
    if (!calm && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_query();
    rx_item_t it;
    it.mode = MODE_QUERY;
    it.rx_data = {$urandom, $urandom};
    it.rx_end = 1'($urandom);
    it.query_ip = $urandom;
    push_item(it, 1'b0, 48'h0, 32'h0);
  endtask

  // received words in order, last one marked, with the odd query slipped in
  task automatic drive_words(input logic [63:0] fw [$]);
    rx_item_t it;
    int i;
    for (i = 0; i < fw.size(); i++) begin
      if ($urandom_range(19) == 0)
        send_query();
      it.mode = MODE_RX;
      it.rx_data = fw[i];
      it.rx_end = (i == fw.size() - 1);
      it.query_ip = $urandom;
      push_item(it, 1'b0, 48'h0, 32'h0);
    end
  endtask

  // hold the sender until every result is out and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outgoing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_addrs(input logic [47:0] mac, input logic [31:0] ip);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_addr <= CFG_OWN_IP;
    cfg_wdata <= {16'($urandom), ip};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    my_mac = mac;
    my_ip = ip;
  endtask

  // mostly well-formed frames, plus queries, truncated frames and noise
  task automatic run_random(input int quota, input bit with_wrap);
    logic [63:0] fw [$];
    hdr_words_t hw;
    int r;
    int n;
    int i;
    items_done = 0;
    // one frame long enough for the word counter to wrap and parse again
    if (with_wrap) begin
      hw = pack_hdr(make_hdr());
      for (i = 0; i < 6; i++) fw.push_back(hw[i]);
      for (i = 6; i < 256; i++) fw.push_back({$urandom, $urandom});
      hw = pack_hdr(make_hdr());
      for (i = 0; i < 6; i++) fw.push_back(hw[i]);
      drive_words(fw);
    end
    while (items_done < quota) begin
      r = $urandom_range(99);
      fw.delete();
      if (r < 55) begin
        hw = pack_hdr(make_hdr());
        n = $urandom_range(6, 9);
        for (i = 0; i < n; i++) begin
          if (i < 6)
            fw.push_back(hw[i]);
          else
            fw.push_back({$urandom, $urandom});
        end
        drive_words(fw);
      end else if (r < 72) begin
        send_query();
      end else if (r < 82) begin
        hw = pack_hdr(make_hdr());
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) fw.push_back(hw[i]);
        drive_words(fw);
      end else if (r < 94) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) fw.push_back({$urandom, $urandom});
        drive_words(fw);
      end else if (r < 96) begin
        settle();
      end else begin
        send_query();
      end
    end
  endtask

  task automatic cmp(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
    end
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    arp_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (outgoing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t unexpected result: expected none actual kind %b data %h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = outgoing_q.pop_front();
        cmp("kind", 64'(want.kind), 64'(out_tuser));
        cmp("tx_data", want.tx_data, out_tdata[63:0]);
        cmp("tx_keep", 64'(want.tx_keep), 64'(out_tdata[71:64]));
        cmp("tx_end", 64'(want.tx_end), 64'(out_tlast));
        cmp("bind_mac", 64'(want.bind_mac), 64'(out_tdata[119:72]));
        cmp("bind_ip", 64'(want.bind_ip), 64'(out_tdata[151:120]));
        cmp("run_last", 64'(want.run_last), 64'(out_tdata[152]));
        cmp("pad", 64'h0, 64'(out_tdata[159:153]));
      end
    end
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // reset, directed table, then register settings with random traffic
  initial begin
    rx_item_t it;
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // registers still at reset values here
    for (i = 0; i < 24; i++) begin
      it.mode = frame_rows[i].mode;
      it.rx_data = frame_rows[i].rx_data;
      it.rx_end = frame_rows[i].rx_end;
      it.query_ip = frame_rows[i].query_ip;
      push_item(it, frame_rows[i].has_bind, frame_rows[i].bind_mac, frame_rows[i].bind_ip);
    end
    settle();
    load_addrs(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    run_random(30, 1'b0);
    settle();
    load_addrs(48'({$urandom, $urandom}), $urandom);
    run_random(290, 1'b1);
    settle();
    // back-to-back stretch, neither side idles but for the odd settle
    calm = 1'b1;
    load_addrs(48'h0, $urandom);
    run_random(60, 1'b0);
    settle();
    calm = 1'b0;
    load_addrs(48'({$urandom, $urandom}), 32'h0);
    run_random(25, 1'b0);
    settle();
    load_addrs(48'({$urandom, $urandom}), $urandom);
    run_random(25, 1'b0);
    settle();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/arp_pkg.sv
rtl/arp_responder.sv
dv/tb_top.sv
